// ===== src/tdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared types and codes for the table-driven DFA recogniser: transaction
// payloads, item kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tdfa_pkg;

    localparam int STATE_COUNT_MAX_DEF  = 32;
    localparam int SYMBOL_COUNT_MAX_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int STATE_W  = 5;
    localparam int SYMIDX_W = 4;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = STATE_W + 1;
    localparam int DEST_VALID_BIT = STATE_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SYM_CNT_W   = 5;
    localparam int MASK_W      = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE_TRANS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_CHAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN_SYMBOL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY       = 2'd3;

    // status codes; FAIL_NONE shares the encoding of an accepted string
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT          = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_IN_ALPHABET = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_TRANSITION   = 2'd3;
    localparam logic [STATUS_W-1:0] FAIL_NONE              = 2'd0;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STATE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_MASK  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATE_W-1:0]  state_index;
        logic [SYMIDX_W-1:0] symbol_index;
        logic [STATE_W-1:0]  dest_state;
        logic                dest_valid;
        logic [CHAR_W-1:0]   symbol_char;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  final_state;
        logic                accepted;
    } t_out_item;

endpackage

// ===== src/table_driven_dfa_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer_unit
// Programmable DFA string recogniser with its transition table held in a
// synchronous memory and the alphabet matched in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one item per
//   transaction: a transition write, an alphabet write, one symbol of a
//   string (flagged last on the final symbol) or an empty-string query.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one
//   result per finished string or empty-string query.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while the block is idle.
// Sequencing:
//   Table and alphabet writes complete as they are taken. A symbol first
//   reads the table memory, then folds the read data into the current
//   state, which the next symbol's lookup address needs; no new item is
//   taken while the second stage holds one. An empty-string query also
//   passes the second stage before its result is registered at the output.
// Reset (synchronous, active low) clears the configuration registers, the
//   string status and the output valid flag; table and alphabet are undefined
//   until written. When the receiver stalls, the output register holds its
//   result; loads and non-final symbols are still taken, and a finishing
//   item waits in the second stage until the output register frees.
// ----------------------------------------------------------------------------
module table_driven_dfa_recognizer_unit
    import tdfa_pkg::*;
#(
    parameter int StateCountMax  = STATE_COUNT_MAX_DEF,
    parameter int SymbolCountMax = SYMBOL_COUNT_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data
);

    localparam int TableDepth = StateCountMax * SymbolCountMax;
    localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int IdxW       = (SymbolCountMax > 1) ? $clog2(SymbolCountMax) : 1;

    // configuration
    logic [SYM_CNT_W-1:0] r_symbol_count;
    logic [STATE_W-1:0]   r_start_state;
    logic [MASK_W-1:0]    r_accept_mask;

    // string status
    logic [STATE_W-1:0]  r_cur_state;
    logic                r_in_string;
    logic [STATUS_W-1:0] r_fail;

    // stores
    logic [ENTRY_W-1:0] r_table [TableDepth];
    logic [ENTRY_W-1:0] r_rdata;
    logic [CHAR_W-1:0]  r_alpha [SymbolCountMax];

    // second stage
    logic                r_s2_valid;
    logic                r_s2_empty;
    logic                r_s2_last;
    logic [STATE_W-1:0]  r_s2_state;
    logic [STATUS_W-1:0] r_s2_fail;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    // front-end signals
    logic                in_fire;
    logic                found;
    logic [IdxW-1:0]     match_idx;
    logic [STATE_W-1:0]  eff_state;
    logic [STATUS_W-1:0] eff_fail;
    logic [STATUS_W-1:0] n_s2_fail;
    logic                tbl_we;
    logic                tbl_re;
    logic                char_we;
    logic [AddrW-1:0]    wr_addr;
    logic [AddrW-1:0]    rd_addr;

    // back-end signals
    logic                out_free;
    logic                s2_emit;
    logic                s2_fire;
    logic [STATE_W-1:0]  n_state;
    logic [STATUS_W-1:0] n_fail;
    logic [STATUS_W-1:0] n_status;

    assign o_in_ready = !r_s2_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= '0;
            r_start_state  <= '0;
            r_accept_mask  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[SYM_CNT_W-1:0];
                CFG_START_STATE:  r_start_state  <= i_cfg_data[STATE_W-1:0];
                CFG_ACCEPT_MASK:  r_accept_mask  <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- front end ----------------
    // highest matching alphabet entry below symbol_count wins
    always_comb begin
        found     = 1'b0;
        match_idx = '0;
        for (int j = 0; j < SymbolCountMax; j++) begin
            if (32'(r_symbol_count) > j && r_alpha[j] == i_in_data.symbol_char) begin
                found     = 1'b1;
                match_idx = IdxW'(j);
            end
        end
    end

    assign eff_state = r_in_string ? r_cur_state : r_start_state;
    assign eff_fail  = r_in_string ? r_fail : FAIL_NONE;

    always_comb begin
        priority if (eff_fail != FAIL_NONE) begin
            n_s2_fail = eff_fail;
        end else if (!found) begin
            n_s2_fail = STATUS_NOT_IN_ALPHABET;
        end else if (32'(eff_state) >= StateCountMax) begin
            n_s2_fail = STATUS_NO_TRANSITION;
        end else begin
            n_s2_fail = FAIL_NONE;
        end
    end

    assign rd_addr = AddrW'(32'(eff_state) * SymbolCountMax + 32'(match_idx));
    assign wr_addr = AddrW'(32'(i_in_data.state_index) * SymbolCountMax
                            + 32'(i_in_data.symbol_index));

    assign tbl_we  = in_fire && i_in_data.kind == KIND_WRITE_TRANS
                     && 32'(i_in_data.state_index) < StateCountMax
                     && 32'(i_in_data.symbol_index) < SymbolCountMax;
    assign tbl_re  = in_fire && i_in_data.kind == KIND_RUN_SYMBOL
                     && n_s2_fail == FAIL_NONE;
    assign char_we = in_fire && i_in_data.kind == KIND_WRITE_CHAR;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[wr_addr] <= {i_in_data.dest_valid, i_in_data.dest_state};
        end
        if (tbl_re) begin
            r_rdata <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SymbolCountMax; j++) begin
            if (char_we && 32'(i_in_data.symbol_index) == j) begin
                r_alpha[j] <= i_in_data.symbol_char;
            end
        end
    end

    // ---------------- second stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_fire && (i_in_data.kind == KIND_RUN_SYMBOL
                                 || i_in_data.kind == KIND_EMPTY)) begin
            r_s2_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2_empty <= i_in_data.kind == KIND_EMPTY;
            r_s2_last  <= i_in_data.last;
            r_s2_state <= (i_in_data.kind == KIND_EMPTY) ? r_start_state : eff_state;
            r_s2_fail  <= (i_in_data.kind == KIND_EMPTY) ? FAIL_NONE : n_s2_fail;
        end
    end

    assign s2_emit = r_s2_empty || r_s2_last;
    assign s2_fire = r_s2_valid && (!s2_emit || out_free);

    // fold the table entry into the state unless empty or failed; set status
    always_comb begin
        n_state = r_s2_state;
        n_fail  = r_s2_fail;
        if (!r_s2_empty && r_s2_fail == FAIL_NONE) begin
            if (r_rdata[DEST_VALID_BIT]) begin
                n_state = r_rdata[STATE_W-1:0];
            end else begin
                n_fail  = STATUS_NO_TRANSITION;
            end
        end
        if (n_fail != FAIL_NONE) begin
            n_status = n_fail;
        end else if (r_accept_mask[n_state]) begin
            n_status = STATUS_ACCEPT;
        end else begin
            n_status = STATUS_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_in_string <= 1'b0;
            r_fail      <= FAIL_NONE;
        end else if (s2_fire) begin
            r_cur_state <= n_state;
            r_in_string <= !s2_emit;
            r_fail      <= s2_emit ? FAIL_NONE : n_fail;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && s2_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && s2_emit) begin
            r_out_data.status      <= n_status;
            r_out_data.final_state <= n_state;
            r_out_data.accepted    <= n_status == STATUS_ACCEPT;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- assertions ----------------
    a_symbol_enters_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.kind == KIND_RUN_SYMBOL) |=> r_s2_valid)
        else $error("accepted symbol did not enter the second stage");

    a_rdata_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && $past(r_s2_valid)) |-> $stable(r_rdata))
        else $error("table read data changed under a pending symbol");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail != STATUS_REJECT)
        else $error("sticky failure holds a non-failure code");

    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.accepted == (o_out_data.status == STATUS_ACCEPT)))
        else $error("accepted flag disagrees with status");

endmodule

// ===== dv/tb_table_driven_dfa_recognizer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_driven_dfa_recognizer_unit
// Self-checking bench for the DFA recogniser. A scoreboard class tracks the
// transition table, alphabet, registers and string state, and predicts the
// verdict of every finished string or empty-string query. Plain tasks drive
// a directed opening and then random strings over several register settings
// and handshake idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
module tb_table_driven_dfa_recognizer_unit;
    import tdfa_pkg::*;

    localparam int TABLE_DEPTH = STATE_COUNT_MAX_DEF * SYMBOL_COUNT_MAX_DEF;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 180;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    t_in_item               in_data     = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    t_out_item              out_data;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_cycles   = 0;
    int settings_used = 0;

    class recognizer_scoreboard;
        logic [ENTRY_W-1:0]  trans_tbl [TABLE_DEPTH];
        bit                  trans_written [TABLE_DEPTH];
        logic [CHAR_W-1:0]   alpha [SYMBOL_COUNT_MAX_DEF];
        bit                  alpha_written [SYMBOL_COUNT_MAX_DEF];
        logic [SYM_CNT_W-1:0] sym_count;
        logic [STATE_W-1:0]  start_st;
        logic [MASK_W-1:0]   acc_mask;
        logic [STATE_W-1:0]  cur_state;
        bit                  in_str;
        logic [STATUS_W-1:0] fail;
        t_out_item           expected_verdicts [$];
        int                  errors;
        int                  items;
        int                  verdicts;
        int                  status_count [4];

        function new();
            sym_count = '0;
            start_st  = '0;
            acc_mask  = '0;
            cur_state = '0;
            in_str    = 1'b0;
            fail      = FAIL_NONE;
            errors    = 0;
            items     = 0;
            verdicts  = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function int symbols_in_use();
            return (sym_count > SYMBOL_COUNT_MAX_DEF) ? SYMBOL_COUNT_MAX_DEF : int'(sym_count);
        endfunction

        // highest matching index wins when characters repeat
        function int match_index(logic [CHAR_W-1:0] ch);
            int idx;
            idx = -1;
            for (int j = 0; j < symbols_in_use(); j++)
                if (alpha[j] == ch) idx = j;
            return idx;
        endfunction

        // table entry the next symbol would read, or -1 when it reads none
        function int lookup_addr(logic [CHAR_W-1:0] ch);
            int idx;
            logic [STATE_W-1:0] st;
            if (in_str && fail != FAIL_NONE) return -1;
            st  = in_str ? cur_state : start_st;
            idx = match_index(ch);
            if (idx < 0) return -1;
            return int'(st) * SYMBOL_COUNT_MAX_DEF + idx;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_SYMBOL_COUNT: sym_count = data[SYM_CNT_W-1:0];
                CFG_START_STATE:  start_st  = data[STATE_W-1:0];
                CFG_ACCEPT_MASK:  acc_mask  = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [STATUS_W-1:0] judge(logic [STATE_W-1:0] st);
            return acc_mask[st] ? STATUS_ACCEPT : STATUS_REJECT;
        endfunction

        function void push_verdict(logic [STATUS_W-1:0] status, logic [STATE_W-1:0] st);
            t_out_item v;
            v.status      = status;
            v.final_state = st;
            v.accepted    = (status == STATUS_ACCEPT);
            expected_verdicts.push_back(v);
        endfunction

        function void step_symbol(logic [CHAR_W-1:0] ch);
            int idx;
            logic [ENTRY_W-1:0] entry;
            idx = match_index(ch);
            if (idx < 0) begin
                fail = STATUS_NOT_IN_ALPHABET;
                return;
            end
            entry = trans_tbl[int'(cur_state) * SYMBOL_COUNT_MAX_DEF + idx];
            if (!entry[DEST_VALID_BIT]) begin
                fail = STATUS_NO_TRANSITION;
                return;
            end
            cur_state = entry[STATE_W-1:0];
        endfunction

        function void apply_item(t_in_item it);
            int a;
            items++;
            case (it.kind)
                KIND_WRITE_TRANS: begin
                    a = int'(it.state_index) * SYMBOL_COUNT_MAX_DEF + int'(it.symbol_index);
                    trans_tbl[a]     = {it.dest_valid, it.dest_state};
                    trans_written[a] = 1'b1;
                end
                KIND_WRITE_CHAR: begin
                    alpha[it.symbol_index]         = it.symbol_char;
                    alpha_written[it.symbol_index] = 1'b1;
                end
                KIND_EMPTY: begin
                    // abandon any string in progress
                    in_str    = 1'b0;
                    fail      = FAIL_NONE;
                    cur_state = start_st;
                    push_verdict(judge(cur_state), cur_state);
                end
                default: begin
                    if (!in_str) begin
                        in_str    = 1'b1;
                        fail      = FAIL_NONE;
                        cur_state = start_st;
                    end
                    // a failure is sticky until the end of the string
                    if (fail == FAIL_NONE) step_symbol(it.symbol_char);
                    if (it.last) begin
                        push_verdict((fail != FAIL_NONE) ? fail : judge(cur_state), cur_state);
                        in_str = 1'b0;
                        fail   = FAIL_NONE;
                    end
                end
            endcase
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result: status %0d, final state %0d, accepted %0d",
                         $time, got.status, got.final_state, got.accepted);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            verdicts++;
            status_count[want.status]++;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.final_state !== want.final_state) begin
                $display("%0t: final_state expected %0d, actual %0d",
                         $time, want.final_state, got.final_state);
                errors++;
            end
            if (got.accepted !== want.accepted) begin
                $display("%0t: accepted expected %0d, actual %0d",
                         $time, want.accepted, got.accepted);
                errors++;
            end
        endfunction
    endclass

    recognizer_scoreboard sb = new();

    table_driven_dfa_recognizer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("Timeout: the block stopped making progress");
        $display("Mismatches found");
        $finish;
    end

    // result side: check what was taken at this edge, then pick the next ready
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_ready && out_valid) sb.check_verdict(out_data);
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    function automatic t_in_item make_item(logic [KIND_W-1:0] kind);
        t_in_item it;
        it      = t_in_item'($urandom);
        it.kind = kind;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        sb.apply_item(it);
    endtask

    task automatic load_transition(input int s, input int y, input int d, input bit v);
        t_in_item it;
        it              = make_item(KIND_WRITE_TRANS);
        it.state_index  = STATE_W'(s);
        it.symbol_index = SYMIDX_W'(y);
        it.dest_state   = STATE_W'(d);
        it.dest_valid   = v;
        send_item(it);
    endtask

    task automatic load_char(input int y, input logic [CHAR_W-1:0] c);
        t_in_item it;
        it              = make_item(KIND_WRITE_CHAR);
        it.symbol_index = SYMIDX_W'(y);
        it.symbol_char  = c;
        send_item(it);
    endtask

    task automatic query_empty();
        send_item(make_item(KIND_EMPTY));
    endtask

    // fill in the table entry first if this symbol would read one never written
    task automatic run_symbol(input logic [CHAR_W-1:0] ch, input bit last);
        int a;
        t_in_item it;
        a = sb.lookup_addr(ch);
        if (a >= 0 && !sb.trans_written[a])
            load_transition(a / SYMBOL_COUNT_MAX_DEF, a % SYMBOL_COUNT_MAX_DEF,
                            $urandom_range(31), $urandom_range(3) != 0);
        it             = make_item(KIND_RUN_SYMBOL);
        it.symbol_char = ch;
        it.last        = last;
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(input int count, input int start, input logic [MASK_W-1:0] mask);
        write_reg(CFG_SYMBOL_COUNT, ($urandom & ~32'h1F) | CFG_DATA_W'(count));
        write_reg(CFG_START_STATE, ($urandom & ~32'h1F) | CFG_DATA_W'(start));
        write_reg(CFG_ACCEPT_MASK, mask);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // hold off until every verdict is in, then let the pipeline settle
    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (sb.expected_verdicts.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_verdicts.size());
            sb.errors += sb.expected_verdicts.size();
            sb.expected_verdicts.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    initial begin
        int r;
        int n;
        int j;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: accepting states 2 and 31, 0x61 repeated at indexes 1 and 4
        write_config(5, 0, 32'h8000_0004);
        load_char(0, 8'h00);
        load_char(1, 8'h61);
        load_char(2, 8'h62);
        load_char(3, 8'hFF);
        load_char(4, 8'h61);
        load_transition(0, 4, 31, 1'b1);
        load_transition(31, 0, 2, 1'b1);
        load_transition(2, 3, 0, 1'b0);
        load_transition(31, 3, 31, 1'b1);
        load_transition(2, 2, 2, 1'b1);
        run_symbol(8'h61, 1'b1);
        run_symbol(8'h61, 1'b0);
        run_symbol(8'h00, 1'b1);
        // missing transition on 0xFF; the trailing symbol is dropped
        run_symbol(8'h61, 1'b0);
        run_symbol(8'h00, 1'b0);
        run_symbol(8'hFF, 1'b0);
        run_symbol(8'h62, 1'b1);
        run_symbol(8'h71, 1'b1);
        query_empty();
        run_symbol(8'h61, 1'b0);
        query_empty();
        // load in the middle of a string
        run_symbol(8'h61, 1'b0);
        load_transition(31, 2, 5, 1'b1);
        run_symbol(8'h62, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            in_idle_pct   = (p == 1) ? 78 : (p == 3 || p == 5) ? 34 : 0;
            out_stall_pct = (p == 2) ? 78 : (p == 3 || p == 5) ? 34 : 0;
            case (p)
                0: write_config(16, 31, $urandom);
                1: write_config(31, $urandom_range(31), 32'h0);
                2: write_config($urandom_range(1, 15), 0, 32'hFFFF_FFFF);
                3: write_config(17, $urandom_range(31), $urandom);
                4: write_config(16, $urandom_range(31), $urandom);
                default: write_config(0, $urandom_range(31), $urandom);
            endcase
            for (int k = 0; k < sb.symbols_in_use(); k++)
                if (!sb.alpha_written[k]) load_char(k, 8'($urandom));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long output stall while input keeps coming, to back up the block
                if (p == 4 && k == 60) hold_cycles = 400;
                r = $urandom_range(99);
                n = sb.symbols_in_use();
                if (r < 8) begin
                    load_transition($urandom_range(31), $urandom_range(15),
                                    $urandom_range(31), $urandom_range(4) != 0);
                end else if (r < 12) begin
                    j = $urandom_range(15);
                    load_char($urandom_range(15),
                              (sb.alpha_written[j] && $urandom_range(1)) ?
                              sb.alpha[j] : 8'($urandom));
                end else if (r < 17) begin
                    query_empty();
                end else if (r < 21 || n == 0) begin
                    run_symbol(8'($urandom), $urandom_range(3) == 0);
                end else begin
                    run_symbol(sb.alpha[$urandom_range(n - 1)], $urandom_range(4) == 0);
                end
            end

            // close any open string before touching the registers
            if (sb.in_str) begin
                n = sb.symbols_in_use();
                run_symbol((n > 0) ? sb.alpha[$urandom_range(n - 1)] : 8'($urandom), 1'b1);
            end
            drain();
        end

        $display("Covered %0d input transactions under %0d register settings,",
                 sb.items, settings_used);
        $display("with idling, stalls and a long output hold-off; checked %0d results:",
                 sb.verdicts);
        $display("%0d accepted, %0d rejected, %0d not in alphabet, %0d no transition.",
                 sb.status_count[STATUS_ACCEPT], sb.status_count[STATUS_REJECT],
                 sb.status_count[STATUS_NOT_IN_ALPHABET], sb.status_count[STATUS_NO_TRANSITION]);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
